/* rtl/mipa_pkg.sv */
// shared types and constants for the multi-interface port allocator
package mipa_pkg;

  localparam int NUM_PORTS  = 1024;
  localparam int NUM_IFACES = 4;
  localparam int IDX_W      = $clog2(NUM_PORTS);
  localparam int WORD_W     = 32;
  localparam int BIT_W      = $clog2(WORD_W);
  localparam int WSEL_W     = IDX_W - BIT_W;
  localparam int SLOT_W     = $clog2(NUM_IFACES);
  localparam int ADDR_W     = SLOT_W + WSEL_W;
  localparam int NWORDS     = NUM_IFACES * (NUM_PORTS / WORD_W);

  localparam logic [1:0] KIND_ALLOC_ANY  = 2'd0;
  localparam logic [1:0] KIND_ALLOC_HINT = 2'd1;
  localparam logic [1:0] KIND_MARK_OCC   = 2'd2;
  localparam logic [1:0] KIND_MARK_FREE  = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_FREE   = 3'd1;
  localparam logic [2:0] ST_OCCUPIED  = 3'd2;
  localparam logic [2:0] ST_FREE      = 3'd3;
  localparam logic [2:0] ST_UNKNOWN   = 3'd4;
  localparam logic [2:0] ST_RANGE     = 3'd5;

  localparam logic [2:0] REG_BASE_PORT  = 3'd0;
  localparam logic [2:0] REG_IFACE_CNT  = 3'd1;
  localparam logic [2:0] REG_IP0        = 3'd2;
  localparam logic [2:0] REG_IP1        = 3'd3;
  localparam logic [2:0] REG_IP2        = 3'd4;
  localparam logic [2:0] REG_IP3        = 3'd5;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] req_ip;
    logic [15:0] req_port;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] got_ip;
    logic [15:0] got_port;
  } rsp_t;

endpackage

/* rtl/multi_interface_port_allocator.sv */
// next-fit bitmap port allocator over several interfaces, bitmap in one word memory
//
//  channel | direction | handshake                | payload
//  in      | input     | in_valid_i / in_ready_o  | in_data_i  (kind, req_ip, req_port)
//  out     | output    | out_valid_o / out_ready_i| out_data_o (status, got_ip, got_port)
//  cfg     | input     | cfg_we_i                 | cfg_idx_i, cfg_data_i
//
// mark occupied / mark free read the word, then modify and write it, then give the result.
// allocation scans 32-bit bitmap words, one read issued per cycle: each interface
// tried costs a setup state (S_SLOT) plus up to 33 word reads in S_SRCH; requests
// rejected at decode go straight to the result.
// one transaction at a time; the next is accepted once the result sits in the
// output register, which holds it while out_ready_i is low.
// reset clears control state and sets the base port to 32768; words never written read as all free via valid bits.
module multi_interface_port_allocator (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mipa_pkg::req_t    in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mipa_pkg::rsp_t    out_data_o,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [31:0]       cfg_data_i
);
  import mipa_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_MEV, S_SLOT, S_SRCH, S_DONE} state_e;

  state_e state_q;

  logic [15:0] base_port_q;
  logic [2:0]  iface_cnt_q;
  logic [31:0] ip_q [NUM_IFACES];

  logic [IDX_W-1:0]  cur_q [NUM_IFACES];
  logic [SLOT_W-1:0] next_q;

  logic [1:0]        kind_q;
  logic [SLOT_W-1:0] slot_q;
  logic [2:0]        tries_q;
  logic [IDX_W-1:0]  idx_q;
  logic [WSEL_W-1:0] sw_q;
  logic [BIT_W-1:0]  sb_q;
  logic [WSEL_W+1:0] kiss_q;
  logic [WSEL_W+1:0] kev_q;
  logic              pend_q;
  rsp_t              res_q;
  logic              out_valid_q;
  rsp_t              out_q;

  // bitmap memory
  logic [WORD_W-1:0] mem [NWORDS];
  logic [NWORDS-1:0] vld_q;
  logic [WORD_W-1:0] rdata_q;
  logic              rvld_q;
  logic [WORD_W-1:0] rword;
  logic              we_c;
  logic [ADDR_W-1:0] waddr_c, raddr_c;
  logic [WORD_W-1:0] wdata_c;

  assign rword = rvld_q ? rdata_q : '1;

  always_ff @(posedge clk_i) begin
    if (we_c) begin
      mem[waddr_c] <= wdata_c;
    end
    rdata_q <= mem[raddr_c];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      rvld_q <= vld_q[raddr_c];
      if (we_c) begin
        vld_q[waddr_c] <= 1'b1;
      end
    end
  end

  // request decode
  logic [2:0]        cnt;
  logic [15:0]       pdiff;
  logic              port_ok;
  logic              found;
  logic [SLOT_W-1:0] mslot;
  logic [SLOT_W-1:0] start_slot;

  assign cnt     = (iface_cnt_q > 3'(NUM_IFACES)) ? 3'(NUM_IFACES) : iface_cnt_q;
  assign pdiff   = in_data_i.req_port - base_port_q;
  assign port_ok = (in_data_i.req_port >= base_port_q) &&
                   ({1'b0, pdiff} < 17'(NUM_PORTS));
  assign start_slot = ({1'b0, next_q} >= cnt) ? '0 : next_q;

  always_comb begin
    found = 1'b0;
    mslot = '0;
    for (int i = NUM_IFACES - 1; i >= 0; i--) begin
      if ((3'(i) < cnt) && (ip_q[i] == in_data_i.req_ip)) begin
        found = 1'b1;
        mslot = SLOT_W'(i);
      end
    end
  end

  // search evaluation
  logic [WSEL_W-1:0] wi;
  logic [WORD_W-1:0] pmask, repr, hits;
  logic [BIT_W-1:0]  pos;
  logic [IDX_W-1:0]  hit_idx;
  logic [2:0]        slot_inc;
  logic [SLOT_W-1:0] slot_nxt;
  logic [16:0]       psum;

  assign wi = sw_q + kev_q[WSEL_W-1:0];

  always_comb begin
    if (kev_q == '0) begin
      pmask = '1 << sb_q;
    end else if (kev_q == (WSEL_W+2)'(NUM_PORTS / WORD_W)) begin
      pmask = ~('1 << sb_q);
    end else begin
      pmask = '1;
    end
  end

  // entries whose port number is zero or above 65535 are skipped
  always_comb begin
    repr = '0;
    psum = '0;
    for (int j = 0; j < WORD_W; j++) begin
      psum    = {1'b0, base_port_q} + 17'({wi, BIT_W'(j)});
      repr[j] = (psum != '0) && !psum[16];
    end
  end

  assign hits = rword & pmask & repr;

  always_comb begin
    pos = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (hits[j]) begin
        pos = BIT_W'(j);
      end
    end
  end

  assign hit_idx  = {wi, pos};
  assign slot_inc = 3'(slot_q) + 3'd1;
  assign slot_nxt = (slot_inc >= cnt) ? '0 : slot_q + SLOT_W'(1);

  // memory port control
  always_comb begin
    we_c    = 1'b0;
    waddr_c = {slot_q, idx_q[IDX_W-1:BIT_W]};
    wdata_c = rword;
    raddr_c = {mslot, pdiff[IDX_W-1:BIT_W]};
    unique case (state_q)
      S_MEV: begin
        if (kind_q == KIND_MARK_OCC) begin
          we_c    = rword[idx_q[BIT_W-1:0]];
          wdata_c = rword & ~(WORD_W'(1) << idx_q[BIT_W-1:0]);
        end else begin
          we_c    = !rword[idx_q[BIT_W-1:0]];
          wdata_c = rword | (WORD_W'(1) << idx_q[BIT_W-1:0]);
        end
      end
      S_SRCH: begin
        raddr_c = {slot_q, sw_q + kiss_q[WSEL_W-1:0]};
        waddr_c = {slot_q, wi};
        wdata_c = rword & ~(WORD_W'(1) << pos);
        we_c    = pend_q && (hits != '0);
      end
      default: ;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      base_port_q  <= 16'd32768;
      iface_cnt_q  <= '0;
      for (int i = 0; i < NUM_IFACES; i++) begin
        ip_q[i]  <= '0;
        cur_q[i] <= '0;
      end
      next_q      <= '0;
      kind_q      <= '0;
      slot_q      <= '0;
      tries_q     <= '0;
      idx_q       <= '0;
      sw_q        <= '0;
      sb_q        <= '0;
      kiss_q      <= '0;
      kev_q       <= '0;
      pend_q      <= 1'b0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && out_ready_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_BASE_PORT:  base_port_q  <= cfg_data_i[15:0];
          REG_IFACE_CNT:  iface_cnt_q  <= cfg_data_i[2:0];
          REG_IP0:        ip_q[0]      <= cfg_data_i;
          REG_IP1:        ip_q[1]      <= cfg_data_i;
          REG_IP2:        ip_q[2]      <= cfg_data_i;
          REG_IP3:        ip_q[3]      <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            kind_q <= in_data_i.kind;
            idx_q  <= pdiff[IDX_W-1:0];
            if (in_data_i.kind == KIND_ALLOC_ANY || in_data_i.kind == KIND_ALLOC_HINT) begin
              if (cnt == '0) begin
                res_q   <= '{status: ST_NO_FREE, got_ip: '0, got_port: '0};
                state_q <= S_DONE;
              end else if (in_data_i.kind == KIND_ALLOC_HINT && !port_ok) begin
                res_q   <= '{status: ST_RANGE, got_ip: '0, got_port: '0};
                state_q <= S_DONE;
              end else begin
                res_q   <= '0;
                next_q  <= start_slot;
                slot_q  <= start_slot;
                tries_q <= '0;
                state_q <= S_SLOT;
              end
            end else if (!found) begin
              res_q   <= '{status: ST_UNKNOWN, got_ip: '0, got_port: '0};
              state_q <= S_DONE;
            end else if (!port_ok) begin
              res_q   <= '{status: ST_RANGE, got_ip: '0, got_port: '0};
              state_q <= S_DONE;
            end else begin
              res_q   <= '0;
              slot_q  <= mslot;
              state_q <= S_MEV;
            end
          end
        end
        S_MEV: begin
          if (kind_q == KIND_MARK_OCC) begin
            res_q.status <= rword[idx_q[BIT_W-1:0]] ? ST_OK : ST_OCCUPIED;
          end else begin
            res_q.status <= rword[idx_q[BIT_W-1:0]] ? ST_FREE : ST_OK;
          end
          state_q <= S_DONE;
        end
        S_SLOT: begin
          if (kind_q == KIND_ALLOC_ANY) begin
            sw_q <= cur_q[slot_q][IDX_W-1:BIT_W];
            sb_q <= cur_q[slot_q][BIT_W-1:0];
          end else begin
            sw_q <= idx_q[IDX_W-1:BIT_W];
            sb_q <= idx_q[BIT_W-1:0];
          end
          kiss_q  <= '0;
          pend_q  <= 1'b0;
          state_q <= S_SRCH;
        end
        S_SRCH: begin
          // one word read issued per cycle, the previous one evaluated
          if (kiss_q <= (WSEL_W+2)'(NUM_PORTS / WORD_W)) begin
            kiss_q <= kiss_q + 1'b1;
            kev_q  <= kiss_q;
            pend_q <= 1'b1;
          end else begin
            pend_q <= 1'b0;
          end
          if (pend_q) begin
            if (hits != '0) begin
              cur_q[slot_q] <= hit_idx + IDX_W'(1);
              next_q        <= slot_nxt;
              res_q         <= '{status: ST_OK, got_ip: ip_q[slot_q],
                                 got_port: base_port_q + 16'(hit_idx)};
              state_q       <= S_DONE;
            end else if (kev_q == (WSEL_W+2)'(NUM_PORTS / WORD_W)) begin
              next_q  <= slot_nxt;
              slot_q  <= slot_nxt;
              tries_q <= tries_q + 3'd1;
              if (tries_q + 3'd1 >= cnt) begin
                res_q.status <= ST_NO_FREE;
                state_q      <= S_DONE;
              end else begin
                state_q <= S_SLOT;
              end
            end
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
